// ===== rtl/sso_pkg.sv =====
// shared types and constants of the sphere shape overlap test
`timescale 1ns / 1ps
package sso_pkg;

    localparam int COORD_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [1:0] {
        OP_SPHERE = 2'd0,
        OP_BOX    = 2'd1,
        OP_CYL    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QX  = 2'd0,
        CFG_QY  = 2'd1,
        CFG_QZ  = 2'd2,
        CFG_RAD = 2'd3
    } t_cfg_idx;

endpackage

// ===== rtl/sso_front.sv =====
// front stage: takes items, forms the offset to the query centre, feeds the queue
`timescale 1ns / 1ps
module sso_front #(
    parameter int COORD_BITS = sso_pkg::COORD_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic signed [COORD_BITS-1:0]            i_qx,
    input  logic signed [COORD_BITS-1:0]            i_qy,
    input  logic signed [COORD_BITS-1:0]            i_qz,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [1:0]                              i_opcode,
    input  logic [3*COORD_BITS-1:0]                 i_shape_center,
    input  logic [3*COORD_BITS-1:0]                 i_axis_first,
    input  logic [3*COORD_BITS-1:0]                 i_axis_second,
    input  logic [3*COORD_BITS-1:0]                 i_axis_third,
    input  logic [3*COORD_BITS-1:0]                 i_box_half_sizes,
    input  logic [COORD_BITS-2:0]                   i_size_first,
    input  logic [COORD_BITS-2:0]                   i_size_second,
    input  logic                                    i_q_full,
    output logic                                    o_push,
    output logic [17*COORD_BITS+3-1:0]              o_job
);
    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int JW = 17 * C + 3;

    logic          r_valid;
    logic [JW-1:0] r_job;
    logic [JW-1:0] n_job;
    logic          w_stall;
    sso_pkg::t_op  w_op;
    logic signed [DW-1:0] w_dx, w_dy, w_dz;

    assign w_stall = r_valid && i_q_full;
    assign o_stall = w_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_job   = r_job;

    // opcode 3 is kept as its own class and answers no hit downstream
    assign w_op = sso_pkg::t_op'(i_opcode);

    assign w_dx = DW'(i_qx) - DW'(signed'(i_shape_center[0*C +: C]));
    assign w_dy = DW'(i_qy) - DW'(signed'(i_shape_center[1*C +: C]));
    assign w_dz = DW'(i_qz) - DW'(signed'(i_shape_center[2*C +: C]));

    assign n_job = {w_op, w_dz, w_dy, w_dx, i_axis_third, i_axis_second, i_axis_first,
                    i_box_half_sizes, i_size_second, i_size_first};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!w_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/sso_queue.sv =====
// short item queue between the front stage and the test pipeline
`timescale 1ns / 1ps
module sso_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sso_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr, n_rd_ptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("item pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("item popped from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost an item");

endmodule

// ===== rtl/sso_back.sv =====
// test pipeline: projections, squares, cylinder cap square root, hit decision
`timescale 1ns / 1ps
module sso_back #(
    parameter int COORD_BITS = sso_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [COORD_BITS-2:0]        i_radius,
    input  logic [17*COORD_BITS+3-1:0]   i_job,
    input  logic                         i_q_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit
);
    localparam int C    = COORD_BITS;
    localparam int SB   = C - 1;
    localparam int AF   = C - 2;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * C + 1;
    localparam int SW   = 2 * C + 3;
    localparam int DDW  = 2 * C + 2;
    localparam int LW   = 2 * C + 4;
    localparam int PRW  = C + 4;
    localparam int TW   = C + 5;
    localparam int PR2W = 2 * C + 8;
    localparam int T2W  = 2 * C + 10;
    localparam int MW   = 2 * C;
    localparam int RW   = 2 * C + 1;
    localparam int WW   = C + 1;
    localparam int W2W  = 2 * C + 2;
    localparam int P4W  = 2 * C + 4;

    // job fields
    logic [1:0]           j_op;
    logic signed [DW-1:0] j_dx, j_dy, j_dz;
    logic [3*C-1:0]       j_a1, j_a2, j_a3, j_half;
    logic [SB-1:0]        j_s1, j_s2;
    logic signed [DW-1:0] w_d  [0:2];
    logic [3*C-1:0]       w_ax [0:2];

    assign {j_op, j_dz, j_dy, j_dx, j_a3, j_a2, j_a1, j_half, j_s2, j_s1} = i_job;
    assign w_d[0]  = j_dx;
    assign w_d[1]  = j_dy;
    assign w_d[2]  = j_dz;
    assign w_ax[0] = j_a1;
    assign w_ax[1] = j_a2;
    assign w_ax[2] = j_a3;

    logic w_en;
    assign w_en  = !(o_valid && i_stall);
    assign o_pop = w_en && !i_q_empty;

    // stage 1: products
    logic                 r_v1;
    logic signed [PW-1:0] r1_pd [0:8];
    logic signed [PW-1:0] r1_sq [0:2];
    logic [MW-1:0]        r1_sph2, r1_sum2, r1_rc2, r1_r4;
    logic [LW-1:0]        r1_hlim [0:2];
    logic [LW-1:0]        r1_farlim, r1_inlim;
    logic [1:0]           r1_op;
    logic [SB-1:0]        r1_h, r1_rc;

    logic signed [PW-1:0] n1_pd [0:8];
    logic signed [PW-1:0] n1_sq [0:2];
    logic [LW-1:0]        n1_hlim [0:2];
    logic [C-1:0]         w_sph, w_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n1_pd[i*3+k] = PW'(w_d[k]) * PW'(signed'(w_ax[i][k*C +: C]));
            end
            n1_sq[i]   = PW'(w_d[i]) * PW'(w_d[i]);
            n1_hlim[i] = (LW'(j_half[i*C +: C]) + LW'(i_radius)) << AF;
        end
    end

    assign w_sph = C'(j_s1) + C'(i_radius);
    assign w_sum = C'(j_s2) + C'(i_radius);

    // stage 2: dot products
    logic             r_v2;
    logic [SW-1:0]    r2_ap [0:2];
    logic [DDW-1:0]   r2_dd;
    logic [MW-1:0]    r2_sph2, r2_sum2, r2_rc2, r2_r4;
    logic [LW-1:0]    r2_hlim [0:2];
    logic [LW-1:0]    r2_farlim, r2_inlim;
    logic [1:0]       r2_op;
    logic [SB-1:0]    r2_h, r2_rc;

    logic signed [SW-1:0] w_p [0:2];
    logic [SW-1:0]        n2_ap [0:2];
    logic [DDW-1:0]       n2_dd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p[i]   = SW'(r1_pd[i*3]) + SW'(r1_pd[i*3+1]) + SW'(r1_pd[i*3+2]);
            n2_ap[i] = w_p[i][SW-1] ? SW'(-w_p[i]) : SW'(w_p[i]);
        end
        n2_dd = DDW'(r1_sq[0]) + DDW'(r1_sq[1]) + DDW'(r1_sq[2]);
    end

    // stage 3: compares and rounding of the axial distance
    logic             r_v3;
    logic             r3_sph, r3_box, r3_far, r3_inh;
    logic [PRW-1:0]   r3_pr;
    logic [TW-1:0]    r3_t;
    logic [DDW-1:0]   r3_dd;
    logic [MW-1:0]    r3_sum2, r3_rc2, r3_r4;
    logic [1:0]       r3_op;
    logic [SB-1:0]    r3_rc;

    logic [LW-1:0]    w_ap0x2, w_round;
    logic [PRW-1:0]   n3_pr;
    logic [TW-1:0]    w_pr2x, n3_t;

    assign w_ap0x2 = LW'(r2_ap[0]) << 1;
    assign w_round = LW'(r2_ap[0]) + (LW'(1) << (AF - 1));
    assign n3_pr   = PRW'(w_round >> AF);
    assign w_pr2x  = TW'(n3_pr) << 1;
    assign n3_t    = (w_pr2x > TW'(r2_h)) ? (w_pr2x - TW'(r2_h)) : '0;

    // stage 4: squares of rounded axial distance and cap offset
    logic             r_v4;
    logic             r4_sph, r4_box, r4_far, r4_inh;
    logic [PR2W-1:0]  r4_pr2;
    logic [T2W-1:0]   r4_t2;
    logic [DDW-1:0]   r4_dd;
    logic [MW-1:0]    r4_sum2, r4_rc2, r4_r4;
    logic [1:0]       r4_op;
    logic [SB-1:0]    r4_rc;

    // stage 5: perpendicular distance and square root operand
    logic             r_v5;
    logic             r5_sph, r5_box, r5_far, r5_inh;
    logic [DDW-1:0]   r5_perp2;
    logic [MW-1:0]    r5_m;
    logic [MW-1:0]    r5_sum2, r5_rc2;
    logic [1:0]       r5_op;
    logic [SB-1:0]    r5_rc;

    logic [DDW-1:0]   n5_perp2;
    logic [MW-1:0]    n5_m;

    assign n5_perp2 = (PR2W'(r4_dd) > r4_pr2) ? DDW'(PR2W'(r4_dd) - r4_pr2) : '0;
    assign n5_m     = (T2W'(r4_r4) > r4_t2) ? MW'(T2W'(r4_r4) - r4_t2) : '0;

    // square root stages: entry 0 holds the early decision, entry j+1 the result of step j
    logic [C:0]       r_sv;
    logic             r_s_known [0:C];
    logic             r_s_val   [0:C];
    logic [DDW-1:0]   r_s_perp2 [0:C];
    logic [SB-1:0]    r_s_rc    [0:C];
    logic [MW-1:0]    r_s_v     [0:C];
    logic [RW-1:0]    r_s_res   [0:C];

    logic [MW-1:0]    n_s_v   [0:C-1];
    logic [RW-1:0]    n_s_res [0:C-1];
    logic [RW:0]      w_trial [0:C-1];
    logic [RW-1:0]    w_bit   [0:C-1];

    logic             w_gt_sum, w_le_rc, n_known, n_val;
    sso_pkg::t_op     w_op5;

    assign w_op5    = sso_pkg::t_op'(r5_op);
    assign w_gt_sum = P4W'(r5_perp2) > P4W'(r5_sum2);
    assign w_le_rc  = P4W'(r5_perp2) <= P4W'(r5_rc2);

    always_comb begin
        n_known = 1'b1;
        n_val   = 1'b0;
        unique case (w_op5)
            sso_pkg::OP_SPHERE: n_val = r5_sph;
            sso_pkg::OP_BOX:    n_val = r5_box;
            sso_pkg::OP_CYL: begin
                if (r5_far || w_gt_sum) begin
                    n_val = 1'b0;
                end else if (r5_inh || w_le_rc) begin
                    n_val = 1'b1;
                end else begin
                    // end cap: decided after the square root
                    n_known = 1'b0;
                end
            end
            sso_pkg::OP_NONE:   n_val = 1'b0;
            default:            n_val = 1'b0;
        endcase
    end

    always_comb begin
        for (int j = 0; j < C; j++) begin
            w_bit[j]   = RW'(1) << (2 * C - 2 - 2 * j);
            w_trial[j] = (RW+1)'(r_s_res[j]) + (RW+1)'(w_bit[j]);
            if ((RW+1)'(r_s_v[j]) >= w_trial[j]) begin
                n_s_v[j]   = r_s_v[j] - MW'(w_trial[j]);
                n_s_res[j] = (r_s_res[j] >> 1) + w_bit[j];
            end else begin
                n_s_v[j]   = r_s_v[j];
                n_s_res[j] = r_s_res[j] >> 1;
            end
        end
    end

    // final stages
    logic             r_vw;
    logic             r_w_known, r_w_val;
    logic [DDW-1:0]   r_w_perp2;
    logic [W2W-1:0]   r_w_w2;
    logic [WW-1:0]    w_w;
    logic             r_out_valid, r_out_hit;
    logic             n_hit;

    assign w_w   = (WW'(r_s_rc[C]) << 1) + WW'(r_s_res[C][C-1:0]);
    assign n_hit = r_w_known ? r_w_val : ((P4W'(r_w_perp2) << 2) <= P4W'(r_w_w2));

    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_sv        <= '0;
            r_vw        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= !i_q_empty;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_sv        <= {r_sv[C-1:0], r_v5};
            r_vw        <= r_sv[C];
            r_out_valid <= r_vw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pd     <= n1_pd;
            r1_sq     <= n1_sq;
            r1_hlim   <= n1_hlim;
            r1_sph2   <= MW'(w_sph) * MW'(w_sph);
            r1_sum2   <= MW'(w_sum) * MW'(w_sum);
            r1_rc2    <= MW'(j_s2) * MW'(j_s2);
            r1_r4     <= (MW'(i_radius) * MW'(i_radius)) << 2;
            r1_farlim <= (LW'(j_s1) + (LW'(i_radius) << 1)) << AF;
            r1_inlim  <= LW'(j_s1) << AF;
            r1_op     <= j_op;
            r1_h      <= j_s1;
            r1_rc     <= j_s2;

            r2_ap     <= n2_ap;
            r2_dd     <= n2_dd;
            r2_sph2   <= r1_sph2;
            r2_sum2   <= r1_sum2;
            r2_rc2    <= r1_rc2;
            r2_r4     <= r1_r4;
            r2_hlim   <= r1_hlim;
            r2_farlim <= r1_farlim;
            r2_inlim  <= r1_inlim;
            r2_op     <= r1_op;
            r2_h      <= r1_h;
            r2_rc     <= r1_rc;

            r3_sph  <= LW'(r2_dd) < LW'(r2_sph2);
            r3_box  <= (LW'(r2_ap[0]) <= r2_hlim[0]) && (LW'(r2_ap[1]) <= r2_hlim[1])
                       && (LW'(r2_ap[2]) <= r2_hlim[2]);
            r3_far  <= w_ap0x2 > r2_farlim;
            r3_inh  <= w_ap0x2 <= r2_inlim;
            r3_pr   <= n3_pr;
            r3_t    <= n3_t;
            r3_dd   <= r2_dd;
            r3_sum2 <= r2_sum2;
            r3_rc2  <= r2_rc2;
            r3_r4   <= r2_r4;
            r3_op   <= r2_op;
            r3_rc   <= r2_rc;

            r4_sph  <= r3_sph;
            r4_box  <= r3_box;
            r4_far  <= r3_far;
            r4_inh  <= r3_inh;
            r4_pr2  <= PR2W'(r3_pr) * PR2W'(r3_pr);
            r4_t2   <= T2W'(r3_t) * T2W'(r3_t);
            r4_dd   <= r3_dd;
            r4_sum2 <= r3_sum2;
            r4_rc2  <= r3_rc2;
            r4_r4   <= r3_r4;
            r4_op   <= r3_op;
            r4_rc   <= r3_rc;

            r5_sph   <= r4_sph;
            r5_box   <= r4_box;
            r5_far   <= r4_far;
            r5_inh   <= r4_inh;
            r5_perp2 <= n5_perp2;
            r5_m     <= n5_m;
            r5_sum2  <= r4_sum2;
            r5_rc2   <= r4_rc2;
            r5_op    <= r4_op;
            r5_rc    <= r4_rc;

            r_s_known[0] <= n_known;
            r_s_val[0]   <= n_val;
            r_s_perp2[0] <= r5_perp2;
            r_s_rc[0]    <= r5_rc;
            r_s_v[0]     <= r5_m;
            r_s_res[0]   <= '0;
            for (int j = 0; j < C; j++) begin
                r_s_known[j+1] <= r_s_known[j];
                r_s_val[j+1]   <= r_s_val[j];
                r_s_perp2[j+1] <= r_s_perp2[j];
                r_s_rc[j+1]    <= r_s_rc[j];
                r_s_v[j+1]     <= n_s_v[j];
                r_s_res[j+1]   <= n_s_res[j];
            end

            r_w_known <= r_s_known[C];
            r_w_val   <= r_s_val[C];
            r_w_perp2 <= r_s_perp2[C];
            r_w_w2    <= W2W'(w_w) * W2W'(w_w);

            r_out_hit <= n_hit;
        end
    end

endmodule

// ===== rtl/sphere_shape_overlap_test_core.sv =====
// sphere shape overlap test: top level with query sphere registers
// throughput: one item per cycle while i_stall stays low; pipeline depth is set by
// the cylinder cap square root, which resolves one result bit per stage
// a queue of QUEUE_DEPTH entries (two by default) sits between the front stage and the test pipeline
// reset (synchronous, active low) clears all valids and the query sphere to zero
`timescale 1ns / 1ps
module sphere_shape_overlap_test_core #(
    parameter int COORD_BITS  = sso_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = sso_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sso_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [COORD_BITS-1:0]             i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [3*COORD_BITS-1:0]           i_shape_center,
    input  logic [3*COORD_BITS-1:0]           i_axis_first,
    input  logic [3*COORD_BITS-1:0]           i_axis_second,
    input  logic [3*COORD_BITS-1:0]           i_axis_third,
    input  logic [3*COORD_BITS-1:0]           i_box_half_sizes,
    input  logic [COORD_BITS-2:0]             i_size_first,
    input  logic [COORD_BITS-2:0]             i_size_second,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit
);
    localparam int JW = 17 * COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;
    logic [COORD_BITS-2:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx     <= '0;
            r_qy     <= '0;
            r_qz     <= '0;
            r_radius <= '0;
        end else if (i_cfg_we) begin
            unique case (sso_pkg::t_cfg_idx'(i_cfg_idx))
                sso_pkg::CFG_QX:  r_qx     <= i_cfg_data;
                sso_pkg::CFG_QY:  r_qy     <= i_cfg_data;
                sso_pkg::CFG_QZ:  r_qz     <= i_cfg_data;
                sso_pkg::CFG_RAD: r_radius <= i_cfg_data[COORD_BITS-2:0];
                default: ;
            endcase
        end
    end

    logic          w_push, w_pop, w_full, w_empty;
    logic [JW-1:0] w_job_in, w_job_out;

    sso_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_qx             (r_qx),
        .i_qy             (r_qy),
        .i_qz             (r_qz),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_shape_center   (i_shape_center),
        .i_axis_first     (i_axis_first),
        .i_axis_second    (i_axis_second),
        .i_axis_third     (i_axis_third),
        .i_box_half_sizes (i_box_half_sizes),
        .i_size_first     (i_size_first),
        .i_size_second    (i_size_second),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_job            (w_job_in)
    );

    sso_queue #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sso_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_radius  (r_radius),
        .i_job     (w_job_out),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_hit     (o_hit)
    );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the sphere shape overlap test core
`timescale 1ns / 1ps
module testbench;

    localparam int CB       = 20;
    localparam int AF       = CB - 2;
    localparam int UNIT     = 1 << AF;
    localparam int DIAG     = 185364;
    localparam int SETTLE   = CB + 20;

    typedef struct {
        sso_pkg::t_op    op;
        logic [3*CB-1:0] center;
        logic [3*CB-1:0] ax1;
        logic [3*CB-1:0] ax2;
        logic [3*CB-1:0] ax3;
        logic [3*CB-1:0] halves;
        logic [CB-2:0]   sz1;
        logic [CB-2:0]   sz2;
    } t_shape;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [1:0]      i_cfg_idx = '0;
    logic [CB-1:0]   i_cfg_data = '0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    logic [1:0]      i_opcode = '0;
    logic [3*CB-1:0] i_shape_center = '0;
    logic [3*CB-1:0] i_axis_first = '0;
    logic [3*CB-1:0] i_axis_second = '0;
    logic [3*CB-1:0] i_axis_third = '0;
    logic [3*CB-1:0] i_box_half_sizes = '0;
    logic [CB-2:0]   i_size_first = '0;
    logic [CB-2:0]   i_size_second = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    logic            o_hit;

    // query sphere as the predictor sees it
    longint qx = 0, qy = 0, qz = 0, qrad = 0;
    bit     hit_q[$];
    int     errors = 0;

    // sender and receiver pacing
    int burst_left = 0;
    bit sender_steady = 0;
    bit rx_quiet = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    sphere_shape_overlap_test_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_shape_center(i_shape_center),
        .i_axis_first(i_axis_first), .i_axis_second(i_axis_second),
        .i_axis_third(i_axis_third), .i_box_half_sizes(i_box_half_sizes),
        .i_size_first(i_size_first), .i_size_second(i_size_second),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint coord(logic [3*CB-1:0] p, int i);
        logic signed [CB-1:0] v;
        v = p[i*CB +: CB];
        return longint'(v);
    endfunction

    function automatic longint dot_with_d(longint d[3], logic [3*CB-1:0] a);
        return d[0] * coord(a, 0) + d[1] * coord(a, 1) + d[2] * coord(a, 2);
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic bit overlap_hit(t_shape s);
        longint d[3];
        longint h, rc, pa, pr, perp2, sm, t, m, w, lim, dd;
        bit hit;
        d[0] = qx - coord(s.center, 0);
        d[1] = qy - coord(s.center, 1);
        d[2] = qz - coord(s.center, 2);
        dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        h  = longint'(s.sz1);
        rc = longint'(s.sz2);
        hit = 0;
        case (s.op)
            sso_pkg::OP_SPHERE: begin
                sm = h + qrad;
                hit = dd < sm * sm;
            end
            sso_pkg::OP_BOX: begin
                hit = 1;
                for (int i = 0; i < 3; i++) begin
                    lim = (longint'(s.halves[i*CB +: CB]) + qrad) <<< AF;
                    pa = dot_with_d(d, i == 0 ? s.ax1 : (i == 1 ? s.ax2 : s.ax3));
                    if (pa < 0) pa = -pa;
                    if (pa > lim) hit = 0;
                end
            end
            sso_pkg::OP_CYL: begin
                pa = dot_with_d(d, s.ax1);
                if (pa < 0) pa = -pa;
                if (2 * pa > ((h + 2 * qrad) <<< AF)) begin
                    hit = 0;
                end else begin
                    pr = (pa + (64'sd1 <<< (AF - 1))) >>> AF;
                    perp2 = dd - pr * pr;
                    if (perp2 < 0) perp2 = 0;
                    sm = rc + qrad;
                    if (perp2 > sm * sm) hit = 0;
                    else if (2 * pa <= (h <<< AF)) hit = 1;
                    else if (perp2 <= rc * rc) hit = 1;
                    else begin
                        // cap rim: circle where the query sphere cuts the cap plane
                        t = 2 * pr - h;
                        if (t < 0) t = 0;
                        m = 4 * qrad * qrad - t * t;
                        if (m < 0) m = 0;
                        w = 2 * rc + floor_sqrt(m);
                        hit = 4 * perp2 <= w * w;
                    end
                end
            end
            default: hit = 0;
        endcase
        return hit;
    endfunction

    // expectation on accept, comparison on each delivered result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                t_shape s;
                s.op = sso_pkg::t_op'(i_opcode);
                s.center = i_shape_center;
                s.ax1 = i_axis_first;
                s.ax2 = i_axis_second;
                s.ax3 = i_axis_third;
                s.halves = i_box_half_sizes;
                s.sz1 = i_size_first;
                s.sz2 = i_size_second;
                hit_q.insert(hit_q.size(), overlap_hit(s));
            end
            if (o_valid && !i_stall) begin
                if (hit_q.size() == 0) begin
                    $error("hit: expected none actual %0d", o_hit);
                    errors++;
                end else begin
                    bit e;
                    e = hit_q.pop_front();
                    if (o_hit !== e) begin
                        $error("hit: expected %0d actual %0d", e, o_hit);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
            i_stall <= 1'b1;
        end else if (rx_quiet) begin
            i_stall <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            case (rx_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (rx_mode_left % 5 < 2);
            endcase
        end
    end

    task automatic send_shape(t_shape s);
        i_valid <= 1'b1;
        i_opcode <= s.op;
        i_shape_center <= s.center;
        i_axis_first <= s.ax1;
        i_axis_second <= s.ax2;
        i_axis_third <= s.ax3;
        i_box_half_sizes <= s.halves;
        i_size_first <= s.sz1;
        i_size_second <= s.sz2;
        do @(posedge i_clk); while (o_stall);
        if (!sender_steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_reg(sso_pkg::t_cfg_idx idx, logic [CB-1:0] val);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (hit_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sso_pkg::CFG_QX:  qx = coord({40'd0, val}, 0);
            sso_pkg::CFG_QY:  qy = coord({40'd0, val}, 0);
            sso_pkg::CFG_QZ:  qz = coord({40'd0, val}, 0);
            default: qrad = longint'(val[CB-2:0]);
        endcase
    endtask

    task automatic set_query(int x, int y, int z, int r);
        write_reg(sso_pkg::CFG_QX, x[CB-1:0]);
        write_reg(sso_pkg::CFG_QY, y[CB-1:0]);
        write_reg(sso_pkg::CFG_QZ, z[CB-1:0]);
        write_reg(sso_pkg::CFG_RAD, r[CB-1:0]);
    endtask

    function automatic logic [3*CB-1:0] pack3(longint a, longint b, longint c);
        logic [CB-1:0] x, y, z;
        x = a[CB-1:0];
        y = b[CB-1:0];
        z = c[CB-1:0];
        return {z, y, x};
    endfunction

    function automatic longint jitter(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [3*CB-1:0] rand_wide();
        return (3*CB)'({$urandom, $urandom});
    endfunction

    // mostly orthonormal frames with random content, now and then noise
    function automatic t_shape make_shape();
        t_shape s;
        int span, k, p, sx, sy, sz;
        longint u[3][3];
        s.op = sso_pkg::t_op'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
        if ($urandom_range(0, 5) == 0) begin
            s.center = rand_wide();
            s.ax1 = rand_wide();
            s.ax2 = rand_wide();
            s.ax3 = rand_wide();
            s.halves = rand_wide();
            s.sz1 = (CB-1)'($urandom);
            s.sz2 = (CB-1)'($urandom);
            return s;
        end
        span = 1 << $urandom_range(4, 14);
        s.center = pack3(qx + jitter(span), qy + jitter(span), qz + jitter(span));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) u[i][j] = 0;
        if ($urandom_range(0, 2) == 0) begin
            u[0][0] = DIAG; u[0][1] = DIAG;
            u[1][0] = -DIAG; u[1][1] = DIAG;
            u[2][2] = UNIT;
        end else begin
            p = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) u[i][(i + p) % 3] = UNIT;
        end
        for (int i = 0; i < 3; i++) begin
            k = $urandom_range(0, 1) ? 1 : -1;
            for (int j = 0; j < 3; j++) u[i][j] = u[i][j] * k;
        end
        s.ax1 = pack3(u[0][0], u[0][1], u[0][2]);
        s.ax2 = pack3(u[1][0], u[1][1], u[1][2]);
        s.ax3 = pack3(u[2][0], u[2][1], u[2][2]);
        sx = $urandom_range(0, span);
        sy = $urandom_range(0, span);
        sz = $urandom_range(0, span);
        s.halves = pack3(sx, sy, sz);
        s.sz1 = (CB-1)'($urandom_range(0, 2 * span));
        s.sz2 = (CB-1)'($urandom_range(0, span));
        return s;
    endfunction

    task automatic test_directed();
        t_shape s;
        set_query(0, 0, 0, 1024);
        s.op = sso_pkg::OP_SPHERE; s.center = pack3(2048, 0, 0);
        s.ax1 = pack3(UNIT, 0, 0); s.ax2 = pack3(0, UNIT, 0); s.ax3 = pack3(0, 0, UNIT);
        s.halves = '0; s.sz1 = 1024; s.sz2 = 0;
        send_shape(s);                              // touching spheres miss
        s.sz1 = 1025; send_shape(s);
        s.op = sso_pkg::OP_BOX; s.halves = pack3(1024, 0, 0); send_shape(s);
        s.halves = '0; send_shape(s);               // zero half sizes
        s.ax2 = pack3(UNIT, UNIT, 0); send_shape(s); // skewed axes
        s.op = sso_pkg::OP_CYL; s.center = pack3(0, 0, 3000); s.ax1 = pack3(0, 0, UNIT);
        s.sz1 = 4000; s.sz2 = 500; send_shape(s);    // cap region
        s.center = pack3(1200, 0, 2500); send_shape(s);
        s.center = pack3(0, 0, 0); s.sz1 = 0; s.sz2 = 0; send_shape(s);
        s.ax1 = pack3(UNIT / 2, 0, 0); s.center = pack3(0, 900, 0);
        s.sz2 = 100; send_shape(s);                  // short direction
        s.op = sso_pkg::OP_NONE; send_shape(s);
        s.op = sso_pkg::OP_CYL; s.center = '1; s.ax1 = '1; s.ax2 = '1; s.ax3 = '1;
        s.halves = '1; s.sz1 = '1; s.sz2 = '1;
        send_shape(s);
        s.op = sso_pkg::OP_BOX; send_shape(s);
        s.op = sso_pkg::OP_SPHERE; send_shape(s);
        s.op = sso_pkg::OP_NONE; send_shape(s);
        set_query(-524288, 524287, -524288, 524287);
        s.center = pack3(524287, -524288, 524287);
        for (int op = 0; op < 4; op++) begin
            s.op = sso_pkg::t_op'(op[1:0]);
            send_shape(s);
        end
        s.op = sso_pkg::OP_CYL; s.ax1 = pack3(-524288, -524288, -524288);
        s.sz1 = 0; s.sz2 = 0;
        send_shape(s);
        s.op = sso_pkg::OP_BOX; s.halves = '0; s.ax2 = s.ax1; s.ax3 = s.ax1;
        send_shape(s);
        set_query(524287, -524288, 524287, 0);
        s.center = '0; s.op = sso_pkg::OP_SPHERE; s.sz1 = 0; send_shape(s);
        s.op = sso_pkg::OP_CYL; s.ax1 = pack3(UNIT, 0, 0); send_shape(s);
    endtask

    task automatic test_random_phase(int n, int x, int y, int z, int r);
        set_query(x, y, z, r);
        repeat (n) send_shape(make_shape());
    endtask

    task automatic test_back_pressure();
        sender_steady = 1;
        hold_req = 1;
        repeat (120) send_shape(make_shape());
        sender_steady = 0;
    endtask

    task automatic test_drain_pause();
        repeat (40) send_shape(make_shape());
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (hit_q.size() == 0);
        @(posedge i_clk);
        repeat (40) send_shape(make_shape());
    endtask

    task automatic test_no_idle();
        sender_steady = 1;
        rx_quiet = 1;
        repeat (100) send_shape(make_shape());
        sender_steady = 0;
        rx_quiet = 0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(200, 0, 0, 0, 2048);
        test_random_phase(150, $urandom_range(0, 4000), -3000, 1500, 0);
        test_random_phase(150, 100000, -200000, 50000, 524287);
        test_back_pressure();
        test_drain_pause();
        test_no_idle();
        test_random_phase(200, -524288, 524287, 0, $urandom_range(0, 20000));
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (hit_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
